FILE: rtl/core/assert_macros.svh
// Assertion macros used by the RTL of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, masked while reset is high.
`define SJS_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also holds during reset.
`define SJS_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/sjs_pkg.sv
// Shared constants, types and saturation helpers of the sparse Jacobi solver.
package sjs_pkg;

   // Sizing
   localparam int MAX_ROWS      = 64;
   localparam int MAX_NONZEROS  = 512;
   localparam int FRACTION_BITS = 16;

   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int N_W    = ROW_W + 1;
   localparam int EA_W   = $clog2(MAX_NONZEROS);
   localparam int CNT_W  = $clog2(MAX_NONZEROS + 1);
   localparam int DSUM_W = 32 + EA_W + 1;

   // Field widths
   localparam int OP_W      = 2;
   localparam int IDX_W     = 6;
   localparam int VAL_W     = 32;
   localparam int ITER_W    = 16;
   localparam int TOL_W     = 16;
   localparam int NROW_W    = 7;
   localparam int ENT_W     = 2 * IDX_W + VAL_W;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 56;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Operation codes
   localparam logic [OP_W-1:0] OP_LOAD_ENTRY = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_RHS   = 2'd1;
   localparam logic [OP_W-1:0] OP_SOLVE      = 2'd2;
   localparam logic [OP_W-1:0] OP_CLEAR      = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ITER = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOL      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS     = 2'd2;

   // Register reset values
   localparam logic [ITER_W-1:0] MAX_ITER_RST = 16'd100;
   localparam logic [TOL_W-1:0]  TOL_RST      = 16'd7;
   localparam logic [NROW_W-1:0] ROWS_RST     = 7'd64;

   // One stored nonzero, row in the low bits
   typedef struct packed {
      logic [VAL_W-1:0] val;
      logic [IDX_W-1:0] col;
      logic [IDX_W-1:0] row;
   } entry_type;

   // Signed 64-bit add with saturation
   function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      return s[63:0];
   endfunction

   // Signed 64-bit subtract with saturation
   function automatic logic [63:0] sat_sub64(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      return s[63:0];
   endfunction

   // Diagonal sum clipped to 32 signed bits
   function automatic logic [31:0] sat32(input logic [DSUM_W-1:0] v);
      if (v[DSUM_W-1:31] == '0 || v[DSUM_W-1:31] == '1) return v[31:0];
      return v[DSUM_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
   endfunction

endpackage

FILE: rtl/core/sjs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sjs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/sjs_div.sv
// Radix-2 restoring divider: signed 64-bit numerator over signed 32-bit
// divisor, quotient truncated toward zero and clipped to 32 signed bits.
module sjs_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num,
   input  logic [31:0] den,
   output logic        done,
   output logic [31:0] quot
);

   logic        busy_ff, busy_in;
   logic        fin_ff, fin_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] nq_ff, nq_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic        neg_ff, neg_in;
   logic [31:0] quot_ff, quot_in;
   logic [32:0] rem_sh;
   logic [32:0] rem_sub;
   logic        qbit;

   // One quotient bit per cycle
   always_comb begin
      rem_sh  = {rem_ff, nq_ff[63]};
      rem_sub = rem_sh - {1'b0, den_ff};
      qbit    = !rem_sub[32];
   end

   always_comb begin
      busy_in = busy_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      nq_in   = nq_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         nq_in   = num[63] ? 64'd0 - num : num;
         rem_in  = '0;
         den_in  = den[31] ? 32'd0 - den : den;
         neg_in  = num[63] != den[31];
      end else if (busy_ff) begin
         nq_in  = {nq_ff[62:0], qbit};
         rem_in = qbit ? rem_sub[31:0] : rem_sh[31:0];
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == '1) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end else if (fin_ff) begin
         // Clip the magnitude and apply the sign
         done_in = 1'b1;
         if (neg_ff) begin
            quot_in = (|nq_ff[63:31]) ? 32'h8000_0000 : 32'd0 - nq_ff[31:0];
         end else begin
            quot_in = (|nq_ff[63:31]) ? 32'h7FFF_FFFF : nq_ff[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      nq_ff   <= nq_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      neg_ff  <= neg_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

FILE: rtl/core/sparse_jacobi_solver_core.sv
// Sparse Jacobi solver core: fixed-point Jacobi iteration over a stored list of nonzeros.
//
// Matrix entry loads, right-hand-side loads and clears are handled in the idle state.
// A solve first sums the diagonal entries (address and entry states per stored nonzero,
// plus an accumulate state for a diagonal one) and checks the n rows for a zero
// diagonal (address and check states per row). Each sweep then walks the whole
// nonzero list (address and entry states per entry that takes no part, plus product
// and accumulate states per off-diagonal entry through the single shared multiplier)
// and updates every row, through the bit-serial divider where its diagonal is nonzero.
// The result phase emits one element at a time, holding each until rsp_tready is high.
// req_tready is high only while no solve is running. All solution, row-sum and diagonal
// storage is held in single-port-read RAMs; no clearing pass is needed.
`include "assert_macros.svh"

module sparse_jacobi_solver_core (
   input  logic                                  clock,
   input  logic                                  reset,
   // request: row[5:0], column[11:6], value[43:12], zero pad
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [sjs_pkg::REQ_DATA_W-1:0]        req_tdata,
   // request: operation[1:0]
   input  logic [sjs_pkg::OP_W-1:0]              req_tuser,
   // response: index[5:0], solution_value[37:6], iterations_used[53:38], zero pad
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [sjs_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // response: converged[0], zero_diagonal[1], store_full[2]
   output logic [2:0]                            rsp_tuser,
   output logic                                  rsp_tlast,
   // configuration writes
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [sjs_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [sjs_pkg::CSR_DATA_W-1:0]        csr_data
);

   localparam int ROW_W  = sjs_pkg::ROW_W;
   localparam int N_W    = sjs_pkg::N_W;
   localparam int EA_W   = sjs_pkg::EA_W;
   localparam int CNT_W  = sjs_pkg::CNT_W;
   localparam int DSUM_W = sjs_pkg::DSUM_W;

   // Sequencer states
   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_DG_ADDR  = 5'd1;
   localparam logic [4:0] S_DG_ENT   = 5'd2;
   localparam logic [4:0] S_DG_ACC   = 5'd3;
   localparam logic [4:0] S_ZD_ADDR  = 5'd4;
   localparam logic [4:0] S_ZD_CHK   = 5'd5;
   localparam logic [4:0] S_ITER     = 5'd6;
   localparam logic [4:0] S_SW_ADDR  = 5'd7;
   localparam logic [4:0] S_SW_ENT   = 5'd8;
   localparam logic [4:0] S_SW_X     = 5'd9;
   localparam logic [4:0] S_SW_ACC   = 5'd10;
   localparam logic [4:0] S_RW_ADDR  = 5'd11;
   localparam logic [4:0] S_RW_LD    = 5'd12;
   localparam logic [4:0] S_RW_START = 5'd13;
   localparam logic [4:0] S_RW_DIV   = 5'd14;
   localparam logic [4:0] S_RW_DIF   = 5'd15;
   localparam logic [4:0] S_RW_NORM  = 5'd16;
   localparam logic [4:0] S_RW_ADD   = 5'd17;
   localparam logic [4:0] S_CHK      = 5'd18;
   localparam logic [4:0] S_OUT_RD   = 5'd19;
   localparam logic [4:0] S_OUT_WT   = 5'd20;
   localparam logic [4:0] S_OUT_HOLD = 5'd21;

   // Registers
   logic [4:0]                   state_ff, state_in;
   logic [sjs_pkg::ITER_W-1:0]   max_iter_ff, max_iter_in;
   logic [sjs_pkg::TOL_W-1:0]    tol_ff, tol_in;
   logic [sjs_pkg::NROW_W-1:0]   rows_ff, rows_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic                         dropped_ff, dropped_in;
   logic [sjs_pkg::MAX_ROWS-1:0] rhs_vld_ff, rhs_vld_in;
   logic [sjs_pkg::MAX_ROWS-1:0] ds_vld_ff, ds_vld_in;
   logic [sjs_pkg::MAX_ROWS-1:0] rs_vld_ff, rs_vld_in;
   logic [CNT_W-1:0]             e_ff, e_in;
   logic [ROW_W-1:0]             r_ff, r_in;
   logic [N_W-1:0]               n_ff, n_in;
   logic [sjs_pkg::ITER_W-1:0]   iter_ff, iter_in;
   logic                         first_ff, first_in;
   logic                         prev_bank_ff, prev_bank_in;
   logic                         out_bank_ff, out_bank_in;
   logic                         conv_ff, conv_in;
   logic                         zdiag_ff, zdiag_in;
   logic [31:0]                  tol2_ff, tol2_in;
   logic [63:0]                  norm_ff, norm_in;
   sjs_pkg::entry_type           ent_ff, ent_in;
   logic [63:0]                  prod_ff, prod_in;
   logic [63:0]                  num_ff, num_in;
   logic [31:0]                  diag_ff, diag_in;
   logic [31:0]                  prev_ff, prev_in;
   logic [31:0]                  cur_ff, cur_in;
   logic [31:0]                  dmag_ff, dmag_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [sjs_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [2:0]                   rsp_user_ff, rsp_user_in;
   logic                         rsp_last_ff, rsp_last_in;

   // Request fields
   logic                         req_fire;
   logic [sjs_pkg::OP_W-1:0]     req_op;
   logic [sjs_pkg::IDX_W-1:0]    req_row;
   logic [sjs_pkg::IDX_W-1:0]    req_col;
   logic [sjs_pkg::VAL_W-1:0]    req_val;
   logic                         row_ok, col_ok;

   // Memory ports
   logic                         ent_we;
   logic [sjs_pkg::ENT_W-1:0]    ent_rd_raw;
   sjs_pkg::entry_type           ent_rd;
   logic                         rhs_we;
   logic [31:0]                  rhs_rd;
   logic                         ds_we;
   logic [ROW_W-1:0]             ds_wa, ds_ra;
   logic [DSUM_W-1:0]            ds_wd, ds_rd, ds_eff;
   logic                         rs_we;
   logic [ROW_W-1:0]             rs_ra;
   logic [63:0]                  rs_wd, rs_rd, rs_eff;
   logic                         x_we;
   logic [ROW_W:0]               x_wa, x_ra;
   logic [31:0]                  x_rd, x_eff;

   // Shared multiplier and divider
   logic signed [32:0]           mul_a, mul_b;
   logic signed [65:0]           mul_p;
   logic                         div_start, div_done;
   logic [31:0]                  div_quot;

   // Working values
   logic                         r_last;
   logic [N_W-1:0]               ent_row_n, ent_col_n;
   logic [32:0]                  diff;
   logic [64:0]                  norm_sum;
   logic [63:0]                  rhs_scaled;

   assign req_op  = req_tuser;
   assign req_row = req_tdata[5:0];
   assign req_col = req_tdata[11:6];
   assign req_val = req_tdata[43:12];
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign row_ok = {1'b0, req_row} < N_W'(sjs_pkg::MAX_ROWS);
   assign col_ok = {1'b0, req_col} < N_W'(sjs_pkg::MAX_ROWS);

   assign ent_rd    = sjs_pkg::entry_type'(ent_rd_raw);
   assign r_last    = (N_W'(r_ff) + N_W'(1)) == n_ff;
   assign ent_row_n = {1'b0, ent_rd.row};
   assign ent_col_n = {1'b0, ent_rd.col};

   // Memory read addresses follow the sequencer phase
   always_comb begin
      ds_ra = r_ff;
      rs_ra = r_ff;
      x_ra  = {prev_bank_ff, r_ff};
      unique case (state_ff)
         S_DG_ENT: ds_ra = ent_rd.row[ROW_W-1:0];
         S_DG_ACC: ds_ra = ent_ff.row[ROW_W-1:0];
         S_SW_ENT: x_ra  = {prev_bank_ff, ent_rd.col[ROW_W-1:0]};
         S_SW_X, S_SW_ACC: rs_ra = ent_ff.row[ROW_W-1:0];
         S_OUT_RD, S_OUT_WT: x_ra = {out_bank_ff, r_ff};
         default: ;
      endcase
   end

   assign ds_eff = ds_vld_ff[ds_ra] ? ds_rd : '0;
   assign rs_eff = rs_vld_ff[rs_ra] ? rs_rd : '0;
   assign x_eff  = first_ff ? 32'd0 : x_rd;

   // Shared multiplier operand selection
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_SW_X: begin
            mul_a = 33'(signed'(ent_ff.val));
            mul_b = 33'(signed'(x_eff));
         end
         S_RW_NORM: begin
            mul_a = {1'b0, dmag_ff};
            mul_b = {1'b0, dmag_ff};
         end
         S_ITER: begin
            mul_a = 33'(tol_ff);
            mul_b = 33'(tol_ff);
         end
         default: ;
      endcase
   end
   assign mul_p = mul_a * mul_b;

   assign diff       = 33'(signed'(cur_ff)) - 33'(signed'(prev_ff));
   assign norm_sum   = {1'b0, norm_ff} + {1'b0, prod_ff};
   assign rhs_scaled = (rhs_vld_ff[r_ff] ? 64'(signed'(rhs_rd)) : 64'd0)
                       <<< sjs_pkg::FRACTION_BITS;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      max_iter_in  = max_iter_ff;
      tol_in       = tol_ff;
      rows_in      = rows_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      rhs_vld_in   = rhs_vld_ff;
      ds_vld_in    = ds_vld_ff;
      rs_vld_in    = rs_vld_ff;
      e_in         = e_ff;
      r_in         = r_ff;
      n_in         = n_ff;
      iter_in      = iter_ff;
      first_in     = first_ff;
      prev_bank_in = prev_bank_ff;
      out_bank_in  = out_bank_ff;
      conv_in      = conv_ff;
      zdiag_in     = zdiag_ff;
      tol2_in      = tol2_ff;
      norm_in      = norm_ff;
      ent_in       = ent_ff;
      prod_in      = prod_ff;
      num_in       = num_ff;
      diag_in      = diag_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      dmag_in      = dmag_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      ent_we       = 1'b0;
      rhs_we       = 1'b0;
      ds_we        = 1'b0;
      ds_wa        = ent_ff.row[ROW_W-1:0];
      ds_wd        = ds_eff + DSUM_W'(signed'(ent_ff.val));
      rs_we        = 1'b0;
      rs_wd        = sjs_pkg::sat_add64(rs_eff, prod_ff);
      x_we         = 1'b0;
      x_wa         = {~prev_bank_ff, r_ff};
      div_start    = 1'b0;

      // Configuration transactions
      if (csr_valid) begin
         unique case (csr_index)
            sjs_pkg::CSR_MAX_ITER: max_iter_in = csr_data;
            sjs_pkg::CSR_TOL:      tol_in      = csr_data;
            sjs_pkg::CSR_ROWS:     rows_in     = csr_data[sjs_pkg::NROW_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               unique case (req_op)
                  sjs_pkg::OP_LOAD_ENTRY: begin
                     if (row_ok && col_ok) begin
                        if (count_ff == CNT_W'(sjs_pkg::MAX_NONZEROS)) begin
                           dropped_in = 1'b1;
                        end else begin
                           ent_we   = 1'b1;
                           count_in = count_ff + CNT_W'(1);
                        end
                     end
                  end
                  sjs_pkg::OP_LOAD_RHS: begin
                     if (row_ok) begin
                        rhs_we = 1'b1;
                        rhs_vld_in[req_row[ROW_W-1:0]] = 1'b1;
                     end
                  end
                  sjs_pkg::OP_SOLVE: begin
                     if (rows_ff == '0) begin
                        n_in = N_W'(1);
                     end else if (rows_ff > sjs_pkg::NROW_W'(sjs_pkg::MAX_ROWS)) begin
                        n_in = N_W'(sjs_pkg::MAX_ROWS);
                     end else begin
                        n_in = N_W'(rows_ff);
                     end
                     e_in         = '0;
                     r_in         = '0;
                     iter_in      = '0;
                     first_in     = 1'b1;
                     conv_in      = 1'b0;
                     zdiag_in     = 1'b0;
                     ds_vld_in    = '0;
                     prev_bank_in = 1'b0;
                     state_in     = S_DG_ADDR;
                  end
                  default: begin
                     count_in   = '0;
                     dropped_in = 1'b0;
                     rhs_vld_in = '0;
                  end
               endcase
            end
         end

         // Diagonal sums
         S_DG_ADDR: begin
            state_in = (e_ff == count_ff) ? S_ZD_ADDR : S_DG_ENT;
            r_in     = '0;
         end
         S_DG_ENT: begin
            ent_in = ent_rd;
            if (ent_rd.row == ent_rd.col && ent_row_n < n_ff) begin
               state_in = S_DG_ACC;
            end else begin
               e_in     = e_ff + CNT_W'(1);
               state_in = S_DG_ADDR;
            end
         end
         S_DG_ACC: begin
            ds_we = 1'b1;
            ds_vld_in[ent_ff.row[ROW_W-1:0]] = 1'b1;
            e_in     = e_ff + CNT_W'(1);
            state_in = S_DG_ADDR;
         end

         // Zero diagonal scan
         S_ZD_ADDR: state_in = S_ZD_CHK;
         S_ZD_CHK: begin
            if (ds_eff == '0) zdiag_in = 1'b1;
            if (r_last) begin
               state_in = S_ITER;
            end else begin
               r_in     = r_ff + ROW_W'(1);
               state_in = S_ZD_ADDR;
            end
         end

         // Sweep start or stop on the sweep limit
         S_ITER: begin
            tol2_in = mul_p[31:0];
            r_in    = '0;
            if (iter_ff == max_iter_ff) begin
               out_bank_in = prev_bank_ff;
               state_in    = S_OUT_RD;
            end else begin
               rs_vld_in = '0;
               e_in      = '0;
               state_in  = S_SW_ADDR;
            end
         end

         // Off-diagonal products into the row sums
         S_SW_ADDR: begin
            r_in    = '0;
            norm_in = '0;
            state_in = (e_ff == count_ff) ? S_RW_ADDR : S_SW_ENT;
         end
         S_SW_ENT: begin
            ent_in = ent_rd;
            if (ent_row_n < n_ff && ent_col_n < n_ff && ent_rd.row != ent_rd.col) begin
               state_in = S_SW_X;
            end else begin
               e_in     = e_ff + CNT_W'(1);
               state_in = S_SW_ADDR;
            end
         end
         S_SW_X: begin
            prod_in  = mul_p[63:0];
            state_in = S_SW_ACC;
         end
         S_SW_ACC: begin
            rs_we = 1'b1;
            rs_vld_in[ent_ff.row[ROW_W-1:0]] = 1'b1;
            e_in     = e_ff + CNT_W'(1);
            state_in = S_SW_ADDR;
         end

         // Row update
         S_RW_ADDR: state_in = S_RW_LD;
         S_RW_LD: begin
            num_in   = sjs_pkg::sat_sub64(rhs_scaled, rs_eff);
            diag_in  = sjs_pkg::sat32(ds_eff);
            prev_in  = x_eff;
            state_in = S_RW_START;
         end
         S_RW_START: begin
            if (diag_ff == '0) begin
               cur_in   = '0;
               state_in = S_RW_DIF;
            end else begin
               div_start = 1'b1;
               state_in  = S_RW_DIV;
            end
         end
         S_RW_DIV: begin
            if (div_done) begin
               cur_in   = div_quot;
               state_in = S_RW_DIF;
            end
         end
         S_RW_DIF: begin
            dmag_in  = diff[32] ? 32'(33'd0 - diff) : diff[31:0];
            state_in = S_RW_NORM;
         end
         S_RW_NORM: begin
            prod_in  = mul_p[63:0];
            x_we     = 1'b1;
            state_in = S_RW_ADD;
         end
         S_RW_ADD: begin
            norm_in = norm_sum[64] ? '1 : norm_sum[63:0];
            if (r_last) begin
               state_in = S_CHK;
            end else begin
               r_in     = r_ff + ROW_W'(1);
               state_in = S_RW_ADDR;
            end
         end

         // Convergence test
         S_CHK: begin
            r_in = '0;
            if (norm_ff < {32'd0, tol2_ff}) begin
               conv_in     = 1'b1;
               first_in    = 1'b0;
               out_bank_in = ~prev_bank_ff;
               state_in    = S_OUT_RD;
            end else begin
               prev_bank_in = ~prev_bank_ff;
               first_in     = 1'b0;
               iter_in      = iter_ff + sjs_pkg::ITER_W'(1);
               state_in     = S_ITER;
            end
         end

         // Result transactions
         S_OUT_RD: state_in = S_OUT_WT;
         S_OUT_WT: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = {2'b00, iter_ff, x_eff, sjs_pkg::IDX_W'(r_ff)};
            rsp_user_in  = {dropped_ff, zdiag_ff, conv_ff};
            rsp_last_in  = r_last;
            state_in     = S_OUT_HOLD;
         end
         S_OUT_HOLD: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  r_in     = r_ff + ROW_W'(1);
                  state_in = S_OUT_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         max_iter_ff  <= sjs_pkg::MAX_ITER_RST;
         tol_ff       <= sjs_pkg::TOL_RST;
         rows_ff      <= sjs_pkg::ROWS_RST;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         rhs_vld_ff   <= '0;
         ds_vld_ff    <= '0;
         rs_vld_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         max_iter_ff  <= max_iter_in;
         tol_ff       <= tol_in;
         rows_ff      <= rows_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         rhs_vld_ff   <= rhs_vld_in;
         ds_vld_ff    <= ds_vld_in;
         rs_vld_ff    <= rs_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      e_ff         <= e_in;
      r_ff         <= r_in;
      n_ff         <= n_in;
      iter_ff      <= iter_in;
      first_ff     <= first_in;
      prev_bank_ff <= prev_bank_in;
      out_bank_ff  <= out_bank_in;
      conv_ff      <= conv_in;
      zdiag_ff     <= zdiag_in;
      tol2_ff      <= tol2_in;
      norm_ff      <= norm_in;
      ent_ff       <= ent_in;
      prod_ff      <= prod_in;
      num_ff       <= num_in;
      diag_ff      <= diag_in;
      prev_ff      <= prev_in;
      cur_ff       <= cur_in;
      dmag_ff      <= dmag_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Nonzero list
   sjs_ram #(.WIDTH(sjs_pkg::ENT_W), .DEPTH(sjs_pkg::MAX_NONZEROS)) u_ent_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (count_ff[EA_W-1:0]),
      .wr_data ({req_val, req_col, req_row}),
      .rd_addr (e_ff[EA_W-1:0]),
      .rd_data (ent_rd_raw)
   );

   // Right-hand side
   sjs_ram #(.WIDTH(32), .DEPTH(sjs_pkg::MAX_ROWS)) u_rhs_ram (
      .clock   (clock),
      .wr_en   (rhs_we),
      .wr_addr (req_row[ROW_W-1:0]),
      .wr_data (req_val),
      .rd_addr (r_ff),
      .rd_data (rhs_rd)
   );

   // Diagonal sums
   sjs_ram #(.WIDTH(DSUM_W), .DEPTH(sjs_pkg::MAX_ROWS)) u_ds_ram (
      .clock   (clock),
      .wr_en   (ds_we),
      .wr_addr (ds_wa),
      .wr_data (ds_wd),
      .rd_addr (ds_ra),
      .rd_data (ds_rd)
   );

   // Off-diagonal row sums
   sjs_ram #(.WIDTH(64), .DEPTH(sjs_pkg::MAX_ROWS)) u_rs_ram (
      .clock   (clock),
      .wr_en   (rs_we),
      .wr_addr (ent_ff.row[ROW_W-1:0]),
      .wr_data (rs_wd),
      .rd_addr (rs_ra),
      .rd_data (rs_rd)
   );

   // Solution, two banks for old and new values
   sjs_ram #(.WIDTH(32), .DEPTH(2 * sjs_pkg::MAX_ROWS)) u_x_ram (
      .clock   (clock),
      .wr_en   (x_we),
      .wr_addr (x_wa),
      .wr_data (cur_ff),
      .rd_addr (x_ra),
      .rd_data (x_rd)
   );

   sjs_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_ff),
      .den   (diag_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Checks
   `SJS_ASSERT(a_last_ends_solve, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast |=> state_ff == S_IDLE, "solve did not end after last element")
   `SJS_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(sjs_pkg::MAX_NONZEROS), "entry count beyond store depth")
   `SJS_ASSERT(a_div_done_phase, clock, reset, div_done |-> state_ff == S_RW_DIV, "divider finished outside the row update")
   `SJS_ASSERT(a_start_not_busy, clock, reset, div_start |=> !div_start, "divider started twice in a row")

endmodule

FILE: bench/sjs_checker.sv
// Checker for the sparse Jacobi solver core: watches all channels, predicts results, compares.
`timescale 1ns / 1ps

module sjs_checker
   import sjs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [OP_W-1:0]       req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic [2:0]            rsp_tuser,
   input  logic                  rsp_tlast,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    errors,
   output int                    pending
);

   typedef struct packed {
      logic [IDX_W-1:0]  index;
      logic [VAL_W-1:0]  value;
      logic              last;
      logic              converged;
      logic [ITER_W-1:0] iters;
      logic              zero_diag;
      logic              full;
   } element_type;

   element_type solution_q[$];

   // predictor copy of registers and stores
   logic [ITER_W-1:0] max_iter_reg;
   logic [TOL_W-1:0]  tol_reg;
   logic [NROW_W-1:0] rows_reg;
   logic [IDX_W-1:0]  ent_row [MAX_NONZEROS];
   logic [IDX_W-1:0]  ent_col [MAX_NONZEROS];
   int                ent_val [MAX_NONZEROS];
   int                ent_count;
   int                rhs_val [MAX_ROWS];
   logic              dropped;

   assign pending = solution_q.size();

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      errors++;
   endtask

   function automatic longint sat_sum(input longint a, input longint b);
      longint s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) return a[63] ? 64'sh8000_0000_0000_0000
                                                         : 64'sh7FFF_FFFF_FFFF_FFFF;
      return s;
   endfunction

   function automatic longint sat_diff(input longint a, input longint b);
      longint s;
      s = a - b;
      if (a[63] != b[63] && s[63] != a[63]) return a[63] ? 64'sh8000_0000_0000_0000
                                                          : 64'sh7FFF_FFFF_FFFF_FFFF;
      return s;
   endfunction

   function automatic longint unsigned magnitude(input longint v);
      return v < 0 ? 64'd0 - longint'(unsigned'(v)) : longint'(unsigned'(v));
   endfunction

   function automatic int clip32(input longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return int'(v);
   endfunction

   // truncating quotient, saturated to 32 bits
   function automatic int quotient(input longint num, input int den);
      longint unsigned q;
      logic neg;
      q = magnitude(num) / magnitude(longint'(den));
      neg = (num < 0) != (den < 0);
      if (neg) begin
         if (q >= 64'd2147483648) return 32'h8000_0000;
         return int'(-longint'(q));
      end
      if (q > 64'd2147483647) return 32'h7FFF_FFFF;
      return int'(q);
   endfunction

   // run the Jacobi sweeps and queue one element per row in use
   task automatic predict_solve();
      int n, r, e, iter;
      logic conv, zdiag;
      longint dsum [MAX_ROWS];
      int diag [MAX_ROWS];
      int cur [MAX_ROWS];
      int prev [MAX_ROWS];
      longint rsum [MAX_ROWS];
      longint unsigned tol2, norm, d, sq;
      longint num;
      element_type el;
      n = rows_reg;
      if (n < 1) n = 1;
      if (n > MAX_ROWS) n = MAX_ROWS;
      iter = 0;
      conv = 0;
      zdiag = 0;
      tol2 = longint'(tol_reg) * longint'(tol_reg);
      for (r = 0; r < MAX_ROWS; r++) begin
         dsum[r] = 0;
         cur[r] = 0;
         prev[r] = 0;
      end
      for (e = 0; e < ent_count; e++)
         if (ent_row[e] < n && ent_row[e] == ent_col[e])
            dsum[ent_row[e]] += longint'(ent_val[e]);
      for (r = 0; r < MAX_ROWS; r++) diag[r] = clip32(dsum[r]);
      for (r = 0; r < n; r++) if (diag[r] == 0) zdiag = 1;
      while (iter < max_iter_reg) begin
         norm = 0;
         for (r = 0; r < n; r++) rsum[r] = 0;
         for (e = 0; e < ent_count; e++)
            if (ent_row[e] < n && ent_col[e] < n && ent_row[e] != ent_col[e])
               rsum[ent_row[e]] = sat_sum(rsum[ent_row[e]],
                  longint'(ent_val[e]) * longint'(prev[ent_col[e]]));
         for (r = 0; r < n; r++) begin
            num = sat_diff(longint'(rhs_val[r]) <<< FRACTION_BITS, rsum[r]);
            cur[r] = (diag[r] == 0) ? 0 : quotient(num, diag[r]);
         end
         for (r = 0; r < n; r++) begin
            d = magnitude(longint'(cur[r]) - longint'(prev[r]));
            sq = (d >= 64'h1_0000_0000) ? '1 : d * d;
            norm = (norm > ~sq) ? '1 : norm + sq;
         end
         if (norm < tol2) begin
            conv = 1;
            break;
         end
         for (r = 0; r < n; r++) prev[r] = cur[r];
         iter++;
      end
      for (r = 0; r < n; r++) begin
         el.index = r;
         el.value = cur[r];
         el.last = (r == n - 1);
         el.converged = conv;
         el.iters = iter;
         el.zero_diag = zdiag;
         el.full = dropped;
         solution_q.push_back(el);
      end
   endtask

   task automatic clear_model();
      ent_count = 0;
      dropped = 0;
      for (int r = 0; r < MAX_ROWS; r++) rhs_val[r] = 0;
   endtask

   // monitor the three channels at each rising edge
   always @(posedge clock) begin
      element_type got, want;
      if (reset) begin
         max_iter_reg = MAX_ITER_RST;
         tol_reg = TOL_RST;
         rows_reg = ROWS_RST;
         clear_model();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MAX_ITER: max_iter_reg = csr_data[ITER_W-1:0];
               CSR_TOL:      tol_reg = csr_data[TOL_W-1:0];
               CSR_ROWS:     rows_reg = csr_data[NROW_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               OP_LOAD_ENTRY: begin
                  if (ent_count >= MAX_NONZEROS) dropped = 1;
                  else begin
                     ent_row[ent_count] = req_tdata[5:0];
                     ent_col[ent_count] = req_tdata[11:6];
                     ent_val[ent_count] = req_tdata[43:12];
                     ent_count++;
                  end
               end
               OP_LOAD_RHS: rhs_val[req_tdata[5:0]] = req_tdata[43:12];
               OP_SOLVE:    predict_solve();
               default:     clear_model();
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.index = rsp_tdata[5:0];
            got.value = rsp_tdata[37:6];
            got.iters = rsp_tdata[53:38];
            got.converged = rsp_tuser[0];
            got.zero_diag = rsp_tuser[1];
            got.full = rsp_tuser[2];
            got.last = rsp_tlast;
            if (solution_q.size() == 0) report("unexpected element", got.index, 0);
            else begin
               want = solution_q.pop_front();
               if (got.index != want.index) report("index", got.index, want.index);
               if (got.value != want.value) report("solution_value", got.value, want.value);
               if (got.last != want.last) report("last", got.last, want.last);
               if (got.converged != want.converged)
                  report("converged", got.converged, want.converged);
               if (got.iters != want.iters) report("iterations_used", got.iters, want.iters);
               if (got.zero_diag != want.zero_diag)
                  report("zero_diagonal", got.zero_diag, want.zero_diag);
               if (got.full != want.full) report("store_full", got.full, want.full);
            end
         end
      end
   end

   initial errors = 0;

endmodule

FILE: bench/tb_sparse_jacobi_solver_core.sv
// Top of the sparse Jacobi solver bench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_sparse_jacobi_solver_core;
   import sjs_pkg::*;

   localparam int CYCLE_LIMIT = 4000000;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_tvalid = 0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [OP_W-1:0]       req_tuser = OP_LOAD_ENTRY;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [2:0]            rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_valid = 0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_MAX_ITER;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   int                    errors, pending;
   int                    cycles = 0;
   logic                  calm = 0;

   always #5 clock = ~clock;

   sparse_jacobi_solver_core u_dut (.*);

   sjs_checker u_checker (.*);

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // result-side backpressure
   always @(negedge clock) begin
      int hold;
      if (hold > 0) hold--;
      else if (calm || $urandom_range(0, 1)) begin
         rsp_tready <= 1;
         hold = $urandom_range(0, 8);
      end else begin
         rsp_tready <= 0;
         hold = gap_len();
      end
   end

   task automatic send(input logic [OP_W-1:0] op, input int row, input int col,
                       input logic [31:0] val);
      int g;
      g = gap_len();
      @(negedge clock);
      if (g > 0) begin
         req_tvalid <= 0;
         repeat (g) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= op;
      req_tdata <= {4'd0, val, col[5:0], row[5:0]};
      forever begin
         @(posedge clock);
         if (req_tready) break;
      end
   endtask

   // wait until every element is out and the core has settled
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int data);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= data[15:0];
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic configure(input int rows, input int iters, input int tol);
      drain();
      write_reg(CSR_ROWS, rows);
      write_reg(CSR_MAX_ITER, iters);
      write_reg(CSR_TOL, tol);
   endtask

   function automatic logic [31:0] signed_mag(input int lo, input int hi);
      int m;
      m = $urandom_range(lo, hi);
      return $urandom_range(0, 1) ? -m : m;
   endfunction

   initial begin
      int n, k, items;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // reset settings, empty stores: every diagonal is zero
      send(OP_SOLVE, 0, 0, 0);
      configure(3, 20, 7);
      // duplicate diagonals saturate
      send(OP_LOAD_ENTRY, 0, 0, 32'h7FFF_FFFF);
      send(OP_LOAD_ENTRY, 0, 0, 32'h7FFF_FFFF);
      send(OP_LOAD_ENTRY, 1, 1, 32'hFFFF_0000);
      send(OP_LOAD_ENTRY, 1, 0, 32'h8000_0000);
      send(OP_LOAD_ENTRY, 2, 2, 0);
      send(OP_LOAD_ENTRY, 0, 63, 32'h0001_0000);
      send(OP_LOAD_ENTRY, 63, 63, 32'hFFFF_FFFF);
      send(OP_LOAD_RHS, 0, 0, 32'h8000_0000);
      send(OP_LOAD_RHS, 1, 63, 32'h7FFF_FFFF);
      send(OP_LOAD_RHS, 63, 0, 32'h1234_5678);
      send(OP_SOLVE, 0, 0, 0);
      configure(0, 0, 0);
      send(OP_SOLVE, 0, 0, 0);
      configure(127, 1, 65535);
      send(OP_SOLVE, 63, 63, 32'hFFFF_FFFF);
      configure(2, 65535, 1);
      send(OP_CLEAR, 0, 0, 0);
      send(OP_LOAD_ENTRY, 0, 0, 32'h0002_0000);
      send(OP_LOAD_ENTRY, 1, 1, 32'hFFFD_0000);
      send(OP_LOAD_RHS, 0, 0, 32'h0005_0000);
      send(OP_LOAD_RHS, 1, 0, 32'h0007_8000);
      send(OP_SOLVE, 0, 0, 0);
      send(OP_CLEAR, 0, 0, 0);
      send(OP_SOLVE, 0, 0, 0);
      configure(64, 2, 0);
      for (k = 0; k < 64; k++) send(OP_LOAD_ENTRY, k, k, signed_mag(1, 32'h7FFF_FFFF));
      send(OP_SOLVE, 0, 0, 0);

      // fill the entry store past its end
      configure(4, 2, 100);
      send(OP_CLEAR, 0, 0, 0);
      calm = 1;
      for (k = 0; k < MAX_NONZEROS + 3; k++)
         send(OP_LOAD_ENTRY, $urandom_range(0, 5), $urandom_range(0, 5), $urandom);
      calm = 0;
      send(OP_SOLVE, 0, 0, 0);
      send(OP_CLEAR, 0, 0, 0);
      send(OP_SOLVE, 0, 0, 0);

      // random systems, mostly well formed
      items = 0;
      while (items < 180) begin
         calm = ($urandom_range(0, 5) == 0);
         if ($urandom_range(0, 9) < 8) begin
            n = $urandom_range(1, 6);
            if ($urandom_range(0, 2) == 0)
               configure(n, $urandom_range(1, 24), $urandom_range(0, 3) == 0 ?
                         $urandom : $urandom_range(0, 300));
            send(OP_CLEAR, 0, 0, 0);
            for (k = 0; k < 6; k++)
               send(OP_LOAD_ENTRY, k, k, signed_mag(32'h0001_0000, 32'h0008_0000));
            for (k = 0; k < 6; k++)
               send(OP_LOAD_ENTRY, $urandom_range(0, 5), $urandom_range(0, 5),
                    signed_mag(0, 32'h0000_8000));
            for (k = 0; k < 6; k++)
               send(OP_LOAD_RHS, k, $urandom_range(0, 63), $urandom_range(0, 1) ?
                    $urandom : signed_mag(0, 32'h0010_0000));
            if ($urandom_range(0, 3) == 0)
               send(OP_LOAD_ENTRY, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
            send(OP_SOLVE, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
            items += 20;
         end else begin
            for (k = 0; k < 6; k++) begin
               send($urandom_range(0, 3), $urandom_range(0, 63), $urandom_range(0, 63),
                    $urandom);
               items++;
            end
         end
      end
      calm = 0;

      drain();
      repeat (200) @(negedge clock);
      if (errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
